>>> design/tds_pkg.sv
// ---------------------------------------------------------------------------
// tds_pkg
// Shared types, codes and helpers of the task dispatcher.
// ---------------------------------------------------------------------------
package tds_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 256;
	localparam int unsigned MAX_WORKERS_DEF = 64;
	localparam int unsigned DIV_STEPS       = 32;
	localparam logic [8:0]  COUNT_MAX       = 9'd511;
	localparam logic [4:0]  RESET_CORES     = 5'd4;
	localparam logic [2:0]  RESET_WPC       = 3'd2;

	// config register indexes
	localparam logic [1:0] CFG_CORE_COUNT = 2'd0;
	localparam logic [1:0] CFG_WPC        = 2'd1;

	// commands
	localparam logic [2:0] CMD_SUBMIT_RR   = 3'd0;
	localparam logic [2:0] CMD_SUBMIT_CORE = 3'd1;
	localparam logic [2:0] CMD_TAKE        = 3'd2;
	localparam logic [2:0] CMD_DONE        = 3'd3;
	localparam logic [2:0] CMD_SCALE_UP    = 3'd4;
	localparam logic [2:0] CMD_SCALE_DOWN  = 3'd5;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;
	localparam logic [1:0] STAT_NONE  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RMW,
		ST_LL,
		ST_UP,
		ST_DN
	} state_t;

	typedef struct packed {
		logic [2:0] command;
		logic [4:0] core_sel;
		logic [5:0] worker_sel;
		logic [6:0] scale_amount;
	} request_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] target_worker;
		logic [6:0] active_now;
	} response_t;

	typedef struct packed {
		logic       paused;
		logic [8:0] queued;
		logic [8:0] inflight;
	} entry_t;

	typedef struct packed {
		logic       rd;
		logic [5:0] raddr;
		logic       wr;
		logic [5:0] waddr;
		entry_t     wdata;
		logic       clr;
	} mem_req_t;

	function automatic logic [4:0] eff_cores(input logic [4:0] cc);
		eff_cores = (cc == 5'd0) ? 5'd1 : ((cc > 5'd16) ? 5'd16 : cc);
	endfunction

	function automatic logic [2:0] eff_wpc(input logic [2:0] wpc);
		eff_wpc = (wpc == 3'd0) ? 3'd1 : ((wpc > 3'd4) ? 3'd4 : wpc);
	endfunction

	function automatic logic [6:0] total_f(input logic [4:0] cc, input logic [2:0] wpc,
			input int unsigned maxw);
		logic [6:0] prod;
		prod = {2'b0, eff_cores(cc)} * {4'b0, eff_wpc(wpc)};
		total_f = (32'(prod) > maxw) ? 7'(maxw) : prod;
	endfunction

endpackage

>>> design/task_dispatch_and_scaling.sv
// ---------------------------------------------------------------------------
// task_dispatch_and_scaling
// Round-robin / least-loaded task dispatcher with worker pause and resume.
// ---------------------------------------------------------------------------
// Usage:
//  - Command channel: a transaction is taken at a clock edge with start high
//    and busy low; request carries command, core_sel, worker_sel, scale_amount.
//  - Result channel: done pulses for one cycle with response valid; the
//    receiver cannot stall, so it must take the response in that cycle.
//  - Config: cfg_we/cfg_index/cfg_data write core_count (0) or
//    workers_per_core (1), only while idle; any such write reinitializes all
//    worker state, the round-robin counter and the active count.
//  - Sequence (start edge to done): core out of range, bad worker, no-op and
//    unknown commands answer at once; take/done do one read-modify-write;
//    submit round robin waits for the 32-step bit-serial modulo unit; submit
//    to core does one memory read per worker of the core plus the
//    read-modify-write; scaling does one memory read per scanned worker.
//  - All worker counts live in one single-port-read memory; each scan reads
//    one entry a cycle, and the scaling scans write back the one before it.
//    One command at a time, busy stays high until the result is produced.
//  - Reset: core_count 4, workers_per_core 2, all workers running and empty,
//    active count 8. Entries are tracked by valid bits, so no clearing pass.
// ---------------------------------------------------------------------------
module task_dispatch_and_scaling import tds_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int unsigned MAX_WORKERS = MAX_WORKERS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  request_t  request,
	output logic      done,
	output response_t response,
	input  logic      cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data
);

	state_t     state_q, state_d;
	request_t   req_q, req_d;
	logic [6:0] idx_q, idx_d;       // scan position / entry address
	logic [6:0] cnt_q, cnt_d;       // workers resumed or paused so far
	logic [2:0] lli_q, lli_d;       // position within the core group
	logic [6:0] best_q, best_d;
	logic [9:0] bload_q, bload_d;
	logic [6:0] active_q, active_d;
	logic [31:0] rr_q, rr_d;
	logic [4:0] cc_q, cc_d;
	logic [2:0] wpc_q, wpc_d;
	logic       done_q, done_d;
	response_t  resp_q, resp_d;

	mem_req_t   mreq;
	entry_t     ent;
	logic       div_start, div_done;
	logic [5:0] div_rem;

	// configuration-derived values
	logic [4:0] ec;
	logic [2:0] we;
	logic [6:0] total, minact, act;
	logic       accept, cfg_hit;
	logic [6:0] new_total;
	logic [4:0] cc_new;
	logic [2:0] wpc_new;

	// decision terms shared by the next-state and datapath logic
	logic       core_bad, ws_bad, up_go, dn_go, div_full;
	logic [9:0] load;
	logic       ll_take, ll_more;
	logic [6:0] best_n;
	logic       dn_hit;
	logic [6:0] cnt_up, cnt_dn;
	logic       up_more, dn_more;
	logic [6:0] base;

	assign ec     = eff_cores(cc_q);
	assign we     = eff_wpc(wpc_q);
	assign total  = total_f(cc_q, wpc_q, MAX_WORKERS);
	assign minact = ({2'b0, ec} < total) ? {2'b0, ec} : total;
	assign act    = (active_q == 7'd0) ? 7'd1 : active_q;
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	assign cfg_hit   = cfg_we && ((cfg_index == CFG_CORE_COUNT) || (cfg_index == CFG_WPC));
	assign cc_new    = (cfg_index == CFG_CORE_COUNT) ? cfg_data : cc_q;
	assign wpc_new   = (cfg_index == CFG_WPC) ? cfg_data[2:0] : wpc_q;
	assign new_total = total_f(cc_new, wpc_new, MAX_WORKERS);

	assign base     = {2'b0, request.core_sel} * {4'b0, we};
	assign core_bad = request.core_sel >= ec;
	assign ws_bad   = {1'b0, request.worker_sel} >= total;
	assign up_go    = (active_q < total) && (request.scale_amount != 7'd0);
	assign dn_go    = (active_q > minact) && (request.scale_amount != 7'd0);
	assign div_full = {1'b0, div_rem} >= total;

	// least-loaded scan: first worker wins ties
	assign load    = {1'b0, ent.queued} + {1'b0, ent.inflight};
	assign ll_take = (lli_q == 3'd0) || (load < bload_q);
	assign best_n  = ll_take ? idx_q : best_q;
	assign ll_more = ((lli_q + 3'd1) < we) && ((idx_q + 7'd1) < total);

	assign cnt_up  = cnt_q + {6'd0, ent.paused};
	assign up_more = ((idx_q + 7'd1) < total) && (cnt_up < req_q.scale_amount);
	assign dn_hit  = !ent.paused && (ent.queued == 9'd0) && (ent.inflight == 9'd0);
	assign cnt_dn  = cnt_q + {6'd0, dn_hit};
	assign dn_more = ((idx_q - 7'd1) > minact) && (cnt_dn < req_q.scale_amount);

	tds_mem #(.DEPTH(MAX_WORKERS)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (ent)
	);

	tds_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (rr_q),
		.den    (act),
		.done   (div_done),
		.rem    (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (request.command)
						CMD_SUBMIT_RR:   state_d = ST_DIV;
						CMD_SUBMIT_CORE: state_d = core_bad ? ST_IDLE : ST_LL;
						CMD_TAKE,
						CMD_DONE:        state_d = ws_bad ? ST_IDLE : ST_RMW;
						CMD_SCALE_UP:    state_d = up_go ? ST_UP : ST_IDLE;
						CMD_SCALE_DOWN:  state_d = dn_go ? ST_DN : ST_IDLE;
						default:         state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = div_full ? ST_IDLE : ST_RMW;
				end
			end
			ST_RMW:  state_d = ST_IDLE;
			ST_LL:   state_d = ll_more ? ST_LL : ST_RMW;
			ST_UP:   state_d = up_more ? ST_UP : ST_IDLE;
			ST_DN:   state_d = dn_more ? ST_DN : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and memory requests
	always_comb begin
		req_d     = req_q;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		lli_d     = lli_q;
		best_d    = best_q;
		bload_d   = bload_q;
		active_d  = active_q;
		rr_d      = rr_q;
		cc_d      = cc_q;
		wpc_d     = wpc_q;
		done_d    = 1'b0;
		resp_d    = resp_q;
		mreq      = '0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cfg_hit) begin
					cc_d     = cc_new;
					wpc_d    = wpc_new;
					rr_d     = '0;
					active_d = new_total;
					mreq.clr = 1'b1;
				end else if (accept) begin
					req_d = request;
					cnt_d = '0;
					resp_d.status        = STAT_OK;
					resp_d.target_worker = '0;
					resp_d.active_now    = active_q;
					case (request.command)
						CMD_SUBMIT_RR: begin
							div_start = 1'b1;
							rr_d      = rr_q + 32'd1;
						end
						CMD_SUBMIT_CORE: begin
							if (core_bad) begin
								resp_d.status = STAT_RANGE;
								done_d        = 1'b1;
							end else begin
								idx_d      = base;
								lli_d      = '0;
								mreq.rd    = 1'b1;
								mreq.raddr = base[5:0];
							end
						end
						CMD_TAKE,
						CMD_DONE: begin
							resp_d.target_worker = request.worker_sel;
							idx_d                = {1'b0, request.worker_sel};
							if (ws_bad) begin
								resp_d.status = STAT_NONE;
								done_d        = 1'b1;
							end else begin
								mreq.rd    = 1'b1;
								mreq.raddr = request.worker_sel;
							end
						end
						CMD_SCALE_UP: begin
							idx_d = active_q;
							if (up_go) begin
								mreq.rd    = 1'b1;
								mreq.raddr = active_q[5:0];
							end else begin
								done_d = 1'b1;
							end
						end
						CMD_SCALE_DOWN: begin
							idx_d = active_q;
							if (dn_go) begin
								mreq.rd    = 1'b1;
								mreq.raddr = 6'(active_q - 7'd1);
							end else begin
								done_d = 1'b1;
							end
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			ST_DIV: begin
				if (div_done) begin
					resp_d.target_worker = div_rem;
					idx_d                = {1'b0, div_rem};
					if (div_full) begin
						resp_d.status = STAT_FULL;
						done_d        = 1'b1;
					end else begin
						mreq.rd    = 1'b1;
						mreq.raddr = div_rem;
					end
				end
			end
			ST_RMW: begin
				mreq.waddr = idx_q[5:0];
				mreq.wdata = ent;
				resp_d.target_worker = idx_q[5:0];
				done_d = 1'b1;
				case (req_q.command)
					CMD_SUBMIT_RR,
					CMD_SUBMIT_CORE: begin
						if (ent.queued >= 9'(QUEUE_DEPTH)) begin
							resp_d.status = STAT_FULL;
						end else begin
							mreq.wr            = 1'b1;
							mreq.wdata.queued  = ent.queued + 9'd1;
							if (ent.inflight < COUNT_MAX) begin
								mreq.wdata.inflight = ent.inflight + 9'd1;
							end
						end
					end
					CMD_TAKE: begin
						if (ent.paused || (ent.queued == 9'd0)) begin
							resp_d.status = STAT_NONE;
						end else begin
							mreq.wr           = 1'b1;
							mreq.wdata.queued = ent.queued - 9'd1;
						end
					end
					CMD_DONE: begin
						if (ent.inflight == 9'd0) begin
							resp_d.status = STAT_NONE;
						end else begin
							mreq.wr             = 1'b1;
							mreq.wdata.inflight = ent.inflight - 9'd1;
						end
					end
					default: mreq.wr = 1'b0;
				endcase
			end
			ST_LL: begin
				best_d  = best_n;
				bload_d = ll_take ? load : bload_q;
				mreq.rd = 1'b1;
				if (ll_more) begin
					idx_d      = idx_q + 7'd1;
					lli_d      = lli_q + 3'd1;
					mreq.raddr = 6'(idx_q + 7'd1);
				end else begin
					idx_d      = best_n;
					mreq.raddr = best_n[5:0];
				end
			end
			ST_UP: begin
				// resume a paused worker, read the next one ahead
				cnt_d = cnt_up;
				if (ent.paused) begin
					mreq.wr           = 1'b1;
					mreq.waddr        = idx_q[5:0];
					mreq.wdata        = ent;
					mreq.wdata.paused = 1'b0;
				end
				if (up_more) begin
					idx_d      = idx_q + 7'd1;
					mreq.rd    = 1'b1;
					mreq.raddr = 6'(idx_q + 7'd1);
				end else begin
					active_d          = active_q + cnt_up;
					resp_d.active_now = active_q + cnt_up;
					done_d            = 1'b1;
				end
			end
			ST_DN: begin
				// pause an idle running worker, scanning downward
				cnt_d = cnt_dn;
				if (dn_hit) begin
					mreq.wr           = 1'b1;
					mreq.waddr        = 6'(idx_q - 7'd1);
					mreq.wdata        = ent;
					mreq.wdata.paused = 1'b1;
				end
				if (dn_more) begin
					idx_d      = idx_q - 7'd1;
					mreq.rd    = 1'b1;
					mreq.raddr = 6'(idx_q - 7'd2);
				end else begin
					active_d          = active_q - cnt_dn;
					resp_d.active_now = active_q - cnt_dn;
					done_d            = 1'b1;
				end
			end
			default: done_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= total_f(RESET_CORES, RESET_WPC, MAX_WORKERS);
			rr_q     <= '0;
			cc_q     <= RESET_CORES;
			wpc_q    <= RESET_WPC;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			lli_q    <= '0;
		end else begin
			state_q  <= state_d;
			active_q <= active_d;
			rr_q     <= rr_d;
			cc_q     <= cc_d;
			wpc_q    <= wpc_d;
			done_q   <= done_d;
			cnt_q    <= cnt_d;
			lli_q    <= lli_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q   <= req_d;
		idx_q   <= idx_d;
		best_q  <= best_d;
		bload_q <= bload_d;
		resp_q  <= resp_d;
	end

	assign done     = done_q;
	assign response = resp_q;

`ifndef SYNTH
	// every accepted transaction either finishes at once or keeps busy high
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted transaction neither finished nor in progress");

	// the result appears only when the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	// active count never exceeds the worker pool
	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(response.active_now) <= MAX_WORKERS))
		else $error("active count beyond worker pool");
`endif

endmodule

>>> design/tds_mem.sv
// ---------------------------------------------------------------------------
// tds_mem
// Per-worker state memory, registered read, valid bit per entry.
// ---------------------------------------------------------------------------
module tds_mem import tds_pkg::*; #(
	parameter int unsigned DEPTH = MAX_WORKERS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output entry_t   rdata
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t           mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	entry_t           rd_s1;
	logic             rv_s1;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.rd) begin
			rd_s1 <= mem_q[req.raddr[AW-1:0]];
		end
	end

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_s1 <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.wr) begin
				vld_q[req.waddr[AW-1:0]] <= 1'b1;
			end
			if (req.rd) begin
				rv_s1 <= vld_q[req.raddr[AW-1:0]];
			end
		end
	end

	assign rdata = rv_s1 ? rd_s1 : '0;

endmodule

>>> design/tds_mod.sv
// ---------------------------------------------------------------------------
// tds_mod
// Restoring modulo unit, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tds_mod import tds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [6:0]  den,
	output logic        done,
	output logic [5:0]  rem
);
	logic [31:0] num_q;
	logic [6:0]  den_q;
	logic [5:0]  rem_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [6:0]  trial;

	assign trial = {rem_q, num_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(DIV_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= (trial >= den_q) ? 6'(trial - den_q) : trial[5:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> tb/sv/tb_task_dispatch_and_scaling.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_task_dispatch_and_scaling
// Self-checking bench for the task dispatcher. A directed table is applied
// first, then constrained-by-hand random command streams over several pool
// configurations; every response is compared with a built-in pool model.
// ---------------------------------------------------------------------------
module tb_task_dispatch_and_scaling;
	import tds_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	request_t   request;
	logic       done;
	response_t  response;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [4:0] cfg_data;

	task_dispatch_and_scaling u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .response(response),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ---------------- pool model ----------------
	logic [4:0]  m_cores_reg;
	logic [2:0]  m_wpc_reg;
	logic [8:0]  m_queued   [64];
	logic [8:0]  m_inflight [64];
	logic        m_paused   [64];
	logic [31:0] m_rr;
	logic [6:0]  m_active;

	response_t   pending_resp[$];
	int          fail_cnt;
	int          resp_cnt;
	int          cmd_hits[8];

	function automatic int pool_cores();
		int c;
		c = m_cores_reg;
		if (c < 1) c = 1;
		if (c > 16) c = 16;
		return c;
	endfunction

	function automatic int pool_wpc();
		int c;
		c = m_wpc_reg;
		if (c < 1) c = 1;
		if (c > 4) c = 4;
		return c;
	endfunction

	function automatic int pool_size();
		int t;
		t = pool_cores() * pool_wpc();
		if (t > 64) t = 64;
		return t;
	endfunction

	function automatic void pool_clear();
		for (int i = 0; i < 64; i++) begin
			m_queued[i] = '0;
			m_inflight[i] = '0;
			m_paused[i] = 1'b0;
		end
		m_rr = '0;
		m_active = 7'(pool_size());
	endfunction

	function automatic logic [1:0] enqueue(int w);
		if (m_queued[w] >= 9'd256) return STAT_FULL;
		m_queued[w]++;
		if (m_inflight[w] < COUNT_MAX) m_inflight[w]++;
		return STAT_OK;
	endfunction

	// Works out the response of one command and updates the model state.
	function automatic response_t dispatch_predict(request_t rq);
		response_t r;
		int total, act, tgt, base, best, best_load, ld, n, minact, w;
		total = pool_size();
		r = '0;
		tgt = 0;
		case (rq.command)
			CMD_SUBMIT_RR: begin
				act = (m_active == 0) ? 1 : int'(m_active);
				tgt = int'(m_rr % 32'(act));
				m_rr++;
				r.status = (tgt < total) ? enqueue(tgt) : STAT_FULL;
			end
			CMD_SUBMIT_CORE: begin
				if (rq.core_sel >= pool_cores()) begin
					r.status = STAT_RANGE;
				end else begin
					base = rq.core_sel * pool_wpc();
					best = base;
					best_load = m_queued[base] + m_inflight[base];
					for (int i = 1; i < pool_wpc(); i++) begin
						w = base + i;
						if (w >= total) break;
						ld = m_queued[w] + m_inflight[w];
						if (ld < best_load) begin
							best_load = ld;
							best = w;
						end
					end
					tgt = best;
					r.status = enqueue(best);
				end
			end
			CMD_TAKE: begin
				tgt = rq.worker_sel;
				if (tgt >= total || m_paused[tgt] || m_queued[tgt] == 0) r.status = STAT_NONE;
				else m_queued[tgt]--;
			end
			CMD_DONE: begin
				tgt = rq.worker_sel;
				if (tgt >= total || m_inflight[tgt] == 0) r.status = STAT_NONE;
				else m_inflight[tgt]--;
			end
			CMD_SCALE_UP: begin
				n = 0;
				for (int i = m_active; i < total && n < rq.scale_amount; i++) begin
					if (m_paused[i]) begin
						m_paused[i] = 1'b0;
						n++;
					end
				end
				m_active = m_active + 7'(n);
			end
			CMD_SCALE_DOWN: begin
				minact = pool_cores();
				if (minact > total) minact = total;
				n = 0;
				for (int i = m_active; i > minact && n < rq.scale_amount; i--) begin
					w = i - 1;
					if (!m_paused[w] && m_queued[w] == 0 && m_inflight[w] == 0) begin
						m_paused[w] = 1'b1;
						n++;
					end
				end
				m_active = m_active - 7'(n);
			end
			default: ;
		endcase
		r.target_worker = 6'(tgt);
		r.active_now = m_active;
		return r;
	endfunction

	// ---------------- response checker ----------------
	always @(posedge clk) begin
		response_t exp_r;
		if (arst_n && done) begin
			resp_cnt++;
			if (pending_resp.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %h", $time, response);
				fail_cnt++;
			end else begin
				exp_r = pending_resp.pop_front();
				if (response.status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_r.status, response.status);
					fail_cnt++;
				end
				if (response.target_worker !== exp_r.target_worker) begin
					$display("%0t: target_worker expected %0d actual %0d", $time,
						exp_r.target_worker, response.target_worker);
					fail_cnt++;
				end
				if (response.active_now !== exp_r.active_now) begin
					$display("%0t: active_now expected %0d actual %0d", $time,
						exp_r.active_now, response.active_now);
					fail_cnt++;
				end
			end
		end
	end

	// ---------------- drivers ----------------
	// Issue one transaction: random gap, then hold start until busy is low.
	task automatic send_cmd(request_t rq);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap != 0) begin
			start <= 1'b0;
			request <= request_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= rq;
		@(posedge clk);
		while (busy) @(posedge clk);
		// accepted at this edge
		cmd_hits[rq.command]++;
		pending_resp.push_back(dispatch_predict(rq));
	endtask

	// Send and, when a fixed response is given, also check it against the model.
	task automatic send_known(request_t rq, logic chk, response_t known);
		response_t pred;
		if (chk) begin
			pred = pending_resp.size() ? '0 : '0;
		end
		send_cmd(rq);
		if (chk) begin
			pred = pending_resp[$];
			if (pred !== known) begin
				$display("%0t: table row expected %h, model gives %h", $time, known, pred);
				fail_cnt++;
			end
		end
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		request <= request_t'($urandom);
		while (pending_resp.size() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		// let any in-progress scan finish before touching config
		repeat (80) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [4:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_index <= 2'($urandom);
		cfg_data <= 5'($urandom);
		if (idx == CFG_CORE_COUNT) m_cores_reg = val;
		else m_wpc_reg = val[2:0];
		pool_clear();
		@(posedge clk);
	endtask

	function automatic request_t mk(logic [2:0] c, logic [4:0] core, logic [5:0] w,
			logic [6:0] a);
		request_t rq;
		rq.command = c;
		rq.core_sel = core;
		rq.worker_sel = w;
		rq.scale_amount = a;
		return rq;
	endfunction

	function automatic response_t rs(logic [1:0] s, logic [5:0] w, logic [6:0] a);
		response_t r;
		r.status = s;
		r.target_worker = w;
		r.active_now = a;
		return r;
	endfunction

	// Directed table: request, whether a response is typed in, and that response.
	typedef struct {
		request_t  rq;
		logic      chk;
		response_t rsp;
	} table_row_t;

	task automatic random_cmd();
		request_t rq;
		int total, pick;
		total = pool_size();
		rq = request_t'($urandom);
		pick = $urandom_range(0, 99);
		// mostly in-range, well-formed traffic so the counts build up
		if (pick < 30) rq.command = CMD_SUBMIT_RR;
		else if (pick < 50) rq.command = CMD_SUBMIT_CORE;
		else if (pick < 65) rq.command = CMD_TAKE;
		else if (pick < 80) rq.command = CMD_DONE;
		else if (pick < 88) rq.command = CMD_SCALE_DOWN;
		else if (pick < 96) rq.command = CMD_SCALE_UP;
		else rq.command = 3'($urandom_range(6, 7));
		if ($urandom_range(0, 9) < 8) begin
			rq.core_sel = 5'($urandom_range(0, pool_cores() - 1));
			rq.worker_sel = 6'($urandom_range(0, total - 1));
			rq.scale_amount = 7'($urandom_range(0, 8));
		end
		send_cmd(rq);
	endtask

	// Pile work onto one worker past the queue depth.
	task automatic flood_worker();
		for (int i = 0; i < 260; i++)
			send_cmd(mk(CMD_SUBMIT_CORE, 5'd0, 6'd0, 7'd0));
	endtask

	initial begin
		table_row_t rows[$];
		int cfg_c[6];
		int cfg_w[6];
		fail_cnt = 0;
		resp_cnt = 0;
		foreach (cmd_hits[i]) cmd_hits[i] = 0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		m_cores_reg = RESET_CORES;
		m_wpc_reg = RESET_WPC;
		pool_clear();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: 4 cores x 2 workers, 8 active
		rows.push_back('{mk(CMD_TAKE, 0, 0, 0), 1, rs(STAT_NONE, 0, 8)});
		rows.push_back('{mk(CMD_DONE, 0, 63, 0), 1, rs(STAT_NONE, 63, 8)});
		rows.push_back('{mk(CMD_SUBMIT_RR, 0, 0, 0), 1, rs(STAT_OK, 0, 8)});
		rows.push_back('{mk(CMD_SUBMIT_RR, 0, 0, 0), 1, rs(STAT_OK, 1, 8)});
		rows.push_back('{mk(CMD_SUBMIT_CORE, 31, 0, 0), 1, rs(STAT_RANGE, 0, 8)});
		rows.push_back('{mk(CMD_SUBMIT_CORE, 4, 0, 0), 1, rs(STAT_RANGE, 0, 8)});
		rows.push_back('{mk(CMD_SUBMIT_CORE, 0, 0, 0), 0, '0});
		rows.push_back('{mk(CMD_SUBMIT_CORE, 3, 0, 0), 0, '0});
		rows.push_back('{mk(CMD_TAKE, 0, 1, 0), 0, '0});
		rows.push_back('{mk(CMD_DONE, 0, 1, 0), 0, '0});
		rows.push_back('{mk(CMD_SCALE_UP, 0, 0, 64), 1, rs(STAT_OK, 0, 8)});
		rows.push_back('{mk(CMD_SCALE_DOWN, 0, 0, 127), 0, '0});
		rows.push_back('{mk(CMD_TAKE, 0, 7, 0), 0, '0});
		rows.push_back('{mk(CMD_SCALE_UP, 0, 0, 1), 0, '0});
		rows.push_back('{mk(CMD_SCALE_UP, 0, 0, 127), 0, '0});
		rows.push_back('{mk(3'd6, 31, 63, 127), 0, '0});
		rows.push_back('{mk(3'd7, 0, 0, 0), 0, '0});
		rows.push_back('{mk(CMD_SUBMIT_RR, 0, 0, 0), 0, '0});
		rows.push_back('{mk(CMD_SCALE_DOWN, 0, 0, 0), 0, '0});
		foreach (rows[i]) send_known(rows[i].rq, rows[i].chk, rows[i].rsp);

		// config sweep: extremes, out-of-range values and mid settings
		cfg_c = '{1, 16, 31, 0, 3, 5};
		cfg_w = '{1, 4, 7, 0, 3, 2};
		for (int p = 0; p < 6; p++) begin
			write_cfg(CFG_CORE_COUNT, 5'(cfg_c[p]));
			write_cfg(CFG_WPC, 5'(cfg_w[p]));
			// one worker per core here, so the flood fills its queue
			if (p == 0) flood_worker();
			for (int k = 0; k < 70; k++) random_cmd();
		end
		write_cfg(CFG_CORE_COUNT, 5'd1);
		write_cfg(CFG_WPC, 5'd4);
		for (int k = 0; k < 40; k++) random_cmd();

		drain();
		$display("Covered %0d responses: rr %0d, core %0d, take %0d, done %0d,",
			resp_cnt, cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3]);
		$display("scale up %0d, scale down %0d, unknown %0d, over 14 config writes.",
			cmd_hits[4], cmd_hits[5], cmd_hits[6] + cmd_hits[7]);
		if (fail_cnt == 0 && pending_resp.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
design/tds_pkg.sv
design/tds_mem.sv
design/tds_mod.sv
design/task_dispatch_and_scaling.sv
tb/sv/tb_task_dispatch_and_scaling.sv
